[rtl/assert_macros.svh]
// Assertion helpers used by the parser core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lfp_pkg.sv]
`timescale 1ns / 1ps

package lfp_pkg;

  // Number of sensor contexts held in the context memory.
  localparam int NUM_SENSORS = 2;
  localparam int CTX_AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  // Frame positions.
  localparam logic [3:0] POS_HEAD1   = 4'd0;
  localparam logic [3:0] POS_HEAD2   = 4'd1;
  localparam logic [3:0] POS_DIST_LO = 4'd2;
  localparam logic [3:0] POS_DIST_HI = 4'd3;
  localparam logic [3:0] POS_CHECK   = 4'd8;

  // Request kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register map.
  localparam logic [0:0] REG_HEADER_BYTE_ADDR = 1'b0;
  localparam logic [7:0] HEADER_BYTE_RESET    = 8'd89;

  // One sensor context as stored in the memory.
  typedef struct packed {
    logic [3:0]  pos;
    logic [7:0]  sum;
    logic [15:0] work_dist;
    logic [15:0] held_dist;
    logic        fresh;
  } ctx_t;

endpackage

[rtl/lfp_ctx_mem.sv]
`timescale 1ns / 1ps

module lfp_ctx_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [lfp_pkg::CTX_AW-1:0] rd_addr,
  output lfp_pkg::ctx_t             rd_ctx,
  input  logic                      wr_en,
  input  logic [lfp_pkg::CTX_AW-1:0] wr_addr,
  input  lfp_pkg::ctx_t             wr_ctx
);

  lfp_pkg::ctx_t                     mem [lfp_pkg::NUM_SENSORS];
  logic [lfp_pkg::NUM_SENSORS-1:0]   valid;

  // Context storage, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ctx;
    end
  end

  // An entry reads as all zero until its first write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a write to the same entry in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_ctx <= wr_ctx;
      end else if (valid[rd_addr]) begin
        rd_ctx <= mem[rd_addr];
      end else begin
        rd_ctx <= '0;
      end
    end
  end

endmodule

[rtl/lfp_step.sv]
`timescale 1ns / 1ps

module lfp_step (
  input  lfp_pkg::ctx_t ctx,
  input  logic          req_type,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    header_byte,
  output lfp_pkg::ctx_t ctx_next,
  output logic          frame_good
);

  logic       is_header;
  logic [7:0] sum_add;

  assign is_header = (rx_byte == header_byte);
  assign sum_add   = ctx.sum + rx_byte;

  // Advance the frame parser by one byte, or clear the fresh flag on a read.
  always_comb begin
    ctx_next   = ctx;
    frame_good = 1'b0;
    if (req_type == lfp_pkg::REQ_READ) begin
      ctx_next.fresh = 1'b0;
    end else begin
      case (ctx.pos) inside
        lfp_pkg::POS_HEAD1: begin
          if (is_header) begin
            ctx_next.sum = rx_byte;
            ctx_next.pos = lfp_pkg::POS_HEAD2;
          end else begin
            ctx_next.sum = '0;
          end
        end
        lfp_pkg::POS_HEAD2: begin
          if (is_header) begin
            ctx_next.sum = sum_add;
            ctx_next.pos = lfp_pkg::POS_DIST_LO;
          end else begin
            ctx_next.sum = '0;
            ctx_next.pos = lfp_pkg::POS_HEAD1;
          end
        end
        [lfp_pkg::POS_DIST_LO : lfp_pkg::POS_CHECK - 4'd1]: begin
          ctx_next.sum = sum_add;
          if (ctx.pos == lfp_pkg::POS_DIST_LO) begin
            ctx_next.work_dist = {8'd0, rx_byte};
          end else if (ctx.pos == lfp_pkg::POS_DIST_HI) begin
            ctx_next.work_dist = {rx_byte, ctx.work_dist[7:0]};
          end
          ctx_next.pos = ctx.pos + 4'd1;
        end
        lfp_pkg::POS_CHECK: begin
          if (ctx.sum == rx_byte) begin
            ctx_next.held_dist = ctx.work_dist;
            ctx_next.fresh     = 1'b1;
            frame_good         = 1'b1;
          end
          ctx_next.sum = '0;
          ctx_next.pos = lfp_pkg::POS_HEAD1;
        end
        default: begin
          // Positions past the checksum byte never occur; recover to hunting.
          ctx_next.sum = '0;
          ctx_next.pos = lfp_pkg::POS_HEAD1;
        end
      endcase
    end
  end

endmodule

[rtl/lidar_frame_parser_core.sv]
// An accepted word passes through stage one and then the output register to the master side.
// Throughput: one word per cycle unless the output stalls, each a context read-modify-write.
// Back-to-back words for the same sensor are resolved by write-through on the memory read.
// Reset: synchronous, active high; all sensor contexts read as zero at once, no clearing pass.
// Reset sets header_byte to 89 and empties the pipeline and the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lidar_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  // Slave side.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [0] req_type, [1] sensor_sel
  // Master side.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] distance
  output logic [1:0]  m_tuser,   // [0] fresh, [1] frame_good
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]                 header_byte;
  logic                       adv;
  logic                       s_accept;
  logic                       s_in_range;
  logic                       st1_valid;
  logic                       st1_req;
  logic                       st1_in_range;
  logic [lfp_pkg::CTX_AW-1:0] st1_addr;
  logic [7:0]                 st1_byte;
  lfp_pkg::ctx_t              rd_ctx;
  lfp_pkg::ctx_t              nxt_ctx;
  logic                       step_good;
  logic                       wr_en;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= lfp_pkg::HEADER_BYTE_RESET;
    end else if (psel && penable && pwrite && (paddr == lfp_pkg::REG_HEADER_BYTE_ADDR)) begin
      header_byte <= pwdata[7:0];
    end
  end
  assign prdata = (paddr == lfp_pkg::REG_HEADER_BYTE_ADDR) ? {24'd0, header_byte} : 32'd0;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv        = !m_tvalid || m_tready;
  assign s_tready   = adv;
  assign s_accept   = s_tvalid && adv;
  assign s_in_range = (int'(s_tuser[1]) < lfp_pkg::NUM_SENSORS);

  // Stage one: the word waits here while its context is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (adv) begin
      st1_valid <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      st1_req      <= s_tuser[0];
      st1_in_range <= s_in_range;
      st1_addr     <= lfp_pkg::CTX_AW'(s_tuser[1]);
      st1_byte     <= s_tdata;
    end
  end

  // Context memory, read at accept and written back when stage one moves on.
  assign wr_en = adv && st1_valid && st1_in_range;

  lfp_ctx_mem u_ctx_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_accept && s_in_range),
    .rd_addr (lfp_pkg::CTX_AW'(s_tuser[1])),
    .rd_ctx  (rd_ctx),
    .wr_en   (wr_en),
    .wr_addr (st1_addr),
    .wr_ctx  (nxt_ctx)
  );

  lfp_step u_step (
    .ctx         (rd_ctx),
    .req_type    (st1_req),
    .rx_byte     (st1_byte),
    .header_byte (header_byte),
    .ctx_next    (nxt_ctx),
    .frame_good  (step_good)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st1_valid) begin
      if (st1_in_range) begin
        m_tdata <= nxt_ctx.held_dist;
        m_tuser <= {step_good, rd_ctx.fresh};
      end else begin
        m_tdata <= '0;
        m_tuser <= '0;
      end
    end
  end

  // Checks on the parser pipeline.
  `ASSERT_CLK(a_st1_hold, clk, rst, st1_valid && !adv |=> st1_valid && $stable(st1_addr), "stalled word left stage one")
  `ASSERT_CLK(a_pos_range, clk, rst, wr_en |-> nxt_ctx.pos <= lfp_pkg::POS_CHECK, "frame position out of range")
  `ASSERT_CLK(a_good_latch, clk, rst, wr_en && step_good |-> nxt_ctx.fresh && nxt_ctx.pos == lfp_pkg::POS_HEAD1, "good frame not latched")
  `ASSERT_CLK(a_read_no_good, clk, rst, st1_valid && st1_req == lfp_pkg::REQ_READ |-> !step_good, "read request flagged a frame")

endmodule

[bench/range_frame_checker.sv]
`timescale 1ns / 1ps

// Watches both stream sides and the configuration port of the frame parser.
// Every accepted input word is run through a local copy of the per-sensor
// parser state, and the outcome is queued until the matching output word arrives.
module range_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [0] req_type, [1] sensor_sel
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [15:0] distance
  input  logic [1:0]  m_tuser,   // [0] fresh, [1] frame_good
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    logic [15:0] distance;
    logic        fresh;
    logic        frame_good;
  } range_result_t;

  localparam int REPORT_LIMIT = 10;

  // Local copy of the header setting and of every sensor context.
  logic [7:0]  header_value;
  logic [3:0]  frame_pos [lfp_pkg::NUM_SENSORS];
  logic [7:0]  run_sum   [lfp_pkg::NUM_SENSORS];
  logic [15:0] work_dist [lfp_pkg::NUM_SENSORS];
  logic [15:0] held_dist [lfp_pkg::NUM_SENSORS];
  logic        fresh_bit [lfp_pkg::NUM_SENSORS];

  range_result_t expected_results [$];
  int errors;

  // Applies one input word to the local sensor state and returns its result.
  function automatic range_result_t step_parser(input logic req, input logic sel,
                                                input logic [7:0] b);
    range_result_t r;
    int s;
    logic [3:0] pos;
    r = '0;
    s = int'(sel);
    if (s >= lfp_pkg::NUM_SENSORS) return r;
    pos = frame_pos[s];
    r.fresh = fresh_bit[s];
    if (req == lfp_pkg::REQ_READ) begin
      fresh_bit[s] = 1'b0;
    end else if (pos == lfp_pkg::POS_HEAD1) begin
      // Hunting: only a header byte starts the sum.
      if (b == header_value) begin
        run_sum[s]   = b;
        frame_pos[s] = lfp_pkg::POS_HEAD2;
      end else begin
        run_sum[s] = '0;
      end
    end else if (pos == lfp_pkg::POS_HEAD2) begin
      // A wrong second header byte drops back to hunting.
      if (b == header_value) begin
        run_sum[s]   = run_sum[s] + b;
        frame_pos[s] = lfp_pkg::POS_DIST_LO;
      end else begin
        run_sum[s]   = '0;
        frame_pos[s] = lfp_pkg::POS_HEAD1;
      end
    end else if (pos < lfp_pkg::POS_CHECK) begin
      run_sum[s] = run_sum[s] + b;
      if (pos == lfp_pkg::POS_DIST_LO) begin
        work_dist[s] = {8'h00, b};
      end else if (pos == lfp_pkg::POS_DIST_HI) begin
        work_dist[s] = {b, work_dist[s][7:0]};
      end
      frame_pos[s] = pos + 4'd1;
    end else if (pos == lfp_pkg::POS_CHECK) begin
      // Latch only on a matching checksum; either way start hunting again.
      if (run_sum[s] == b) begin
        held_dist[s] = work_dist[s];
        fresh_bit[s] = 1'b1;
        r.frame_good = 1'b1;
      end
      run_sum[s]   = '0;
      frame_pos[s] = lfp_pkg::POS_HEAD1;
    end else begin
      run_sum[s]   = '0;
      frame_pos[s] = lfp_pkg::POS_HEAD1;
    end
    r.distance = held_dist[s];
    return r;
  endfunction

  // Compare output words first, then queue the prediction for a new input word.
  always @(posedge clk) begin
    range_result_t want;
    if (rst) begin
      header_value = lfp_pkg::HEADER_BYTE_RESET;
      for (int i = 0; i < lfp_pkg::NUM_SENSORS; i++) begin
        frame_pos[i] = lfp_pkg::POS_HEAD1;
        run_sum[i]   = '0;
        work_dist[i] = '0;
        held_dist[i] = '0;
        fresh_bit[i] = 1'b0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == lfp_pkg::REG_HEADER_BYTE_ADDR) begin
        header_value = pwdata[7:0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: unexpected output word: distance %h fresh %b good %b",
                     $time, m_tdata, m_tuser[0], m_tuser[1]);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.distance !== m_tdata || want.fresh !== m_tuser[0] ||
              want.frame_good !== m_tuser[1]) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected distance %h fresh %b good %b, got %h %b %b",
                       $time, want.distance, want.fresh, want.frame_good,
                       m_tdata, m_tuser[0], m_tuser[1]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(step_parser(s_tuser[0], s_tuser[1], s_tdata));
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_results.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Drives serial bytes and read requests into the frame parser, mostly as
// well-formed frames interleaved across sensors, and gives the verdict from
// the checker's mismatch count.
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int FRAME_LEN    = 9;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_SUM,
    FRAME_BAD_HEADER
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int pending_results;
  int send_idle     = 19;
  int recv_idle     = 60;
  int hold_requests = 0;
  int holds_served;
  int stall_left;
  int cycle_count;

  // Header value in force and the planned bytes of each sensor's next frame.
  logic [7:0] header_now;
  logic [7:0] frame_plan [lfp_pkg::NUM_SENSORS][FRAME_LEN];
  int         plan_pos   [lfp_pkg::NUM_SENSORS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lidar_frame_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  range_frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // Offers one word after a random gap and returns at the edge that accepts it.
  task automatic send_word(input logic req, input logic sel, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= {sel, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted output word has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the header register once the parser is idle.
  task automatic write_header(input logic [7:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lfp_pkg::REG_HEADER_BYTE_ADDR;
    pwdata  <= {24'h000000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    header_now = value;
    for (int i = 0; i < lfp_pkg::NUM_SENSORS; i++) plan_pos[i] = FRAME_LEN;
  endtask

  // Plans a full frame for one sensor, optionally with a broken header or checksum.
  function automatic void build_frame(input logic sel, input logic [15:0] range_value,
                                      input frame_flaw_t flaw);
    logic [7:0] sum;
    frame_plan[sel][0] = header_now;
    frame_plan[sel][1] = (flaw == FRAME_BAD_HEADER) ?
                         header_now ^ 8'($urandom_range(255, 1)) : header_now;
    frame_plan[sel][2] = range_value[7:0];
    frame_plan[sel][3] = range_value[15:8];
    for (int k = 4; k < 8; k++) frame_plan[sel][k] = 8'($urandom_range(255));
    sum = '0;
    for (int k = 0; k < 8; k++) sum = sum + frame_plan[sel][k];
    frame_plan[sel][8] = (flaw == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(255, 1)) : sum;
    plan_pos[sel] = 0;
  endfunction

  task automatic send_plan(input logic sel);
    for (int k = 0; k < FRAME_LEN; k++) send_word(lfp_pkg::REQ_BYTE, sel, frame_plan[sel][k]);
    plan_pos[sel] = FRAME_LEN;
  endtask

  // Mostly frame bytes interleaved across sensors, with reads and noise bytes mixed in.
  task automatic send_random_words(input int count);
    int          roll;
    int          dist_roll;
    int          flaw_roll;
    logic        sel;
    logic [15:0] range_value;
    frame_flaw_t flaw;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      sel  = 1'($urandom_range(lfp_pkg::NUM_SENSORS - 1));
      if (roll < 8) begin
        send_word(lfp_pkg::REQ_READ, sel, 8'($urandom_range(255)));
      end else if (roll < 14) begin
        send_word(lfp_pkg::REQ_BYTE, sel, 8'($urandom_range(255)));
      end else begin
        if (plan_pos[sel] >= FRAME_LEN) begin
          dist_roll = $urandom_range(99);
          range_value = (dist_roll < 10) ? 16'h0000 :
                        (dist_roll < 20) ? 16'hFFFF : 16'($urandom_range(65535));
          flaw_roll = $urandom_range(99);
          flaw = (flaw_roll < 15) ? FRAME_BAD_SUM :
                 (flaw_roll < 20) ? FRAME_BAD_HEADER : FRAME_CLEAN;
          build_frame(sel, range_value, flaw);
        end
        send_word(lfp_pkg::REQ_BYTE, sel, frame_plan[sel][plan_pos[sel]]);
        plan_pos[sel]++;
      end
    end
  endtask

  // Receiver: random backpressure, or a long hold-off when one is requested.
  initial begin
    m_tready     = 1'b0;
    holds_served = 0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // Main stimulus.
  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    header_now = lfp_pkg::HEADER_BYTE_RESET;
    for (int i = 0; i < lfp_pkg::NUM_SENSORS; i++) plan_pos[i] = FRAME_LEN;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: hunting byte, bad second header, a good frame at full scale,
    // reads with and without a fresh value, and a frame with a bad checksum.
    send_word(lfp_pkg::REQ_BYTE, 1'b0, 8'h00);
    send_word(lfp_pkg::REQ_BYTE, 1'b0, header_now);
    send_word(lfp_pkg::REQ_BYTE, 1'b0, 8'hFF);
    build_frame(1'b0, 16'hFFFF, FRAME_CLEAN);
    send_plan(1'b0);
    send_word(lfp_pkg::REQ_READ, 1'b0, 8'hFF);
    send_word(lfp_pkg::REQ_READ, 1'b0, 8'h00);
    build_frame(1'b1, 16'h0000, FRAME_BAD_SUM);
    send_plan(1'b1);
    send_word(lfp_pkg::REQ_READ, 1'b1, 8'($urandom_range(255)));

    // Sender idles lightly, receiver heavily.
    write_header(8'h00);
    send_random_words(250);
    write_header(8'hFF);
    send_random_words(250);

    // Sender idles heavily, receiver lightly; includes a long receiver hold-off.
    send_idle = 60;
    recv_idle = 19;
    write_header(8'($urandom_range(255)));
    send_random_words(250);
    hold_requests++;
    send_random_words(40);
    drain_results();
    send_random_words(100);

    // No idling on either side.
    send_idle = 0;
    recv_idle = 0;
    write_header(lfp_pkg::HEADER_BYTE_RESET);
    send_random_words(300);
    write_header(8'($urandom_range(255)));
    send_random_words(260);

    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lfp_pkg.sv
rtl/lfp_ctx_mem.sv
rtl/lfp_step.sv
rtl/lidar_frame_parser_core.sv
bench/range_frame_checker.sv
bench/testbench.sv
